// ----- rtl/process_table_round_robin_defines.svh -----
// ----------------------------------------------------------------------------
// Process table assertion macros
// Shared property shorthands for the process table RTL.
// ----------------------------------------------------------------------------
`ifndef PROCESS_TABLE_ROUND_ROBIN_DEFINES_SVH
`define PROCESS_TABLE_ROUND_ROBIN_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PTRR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PTRR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/ptrr_pkg.sv -----
// ----------------------------------------------------------------------------
// Process table package
// Word types, mode, status and result codes for the process table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ptrr_pkg;

  // Request modes.
  localparam logic [2:0] MODE_ALLOC  = 3'd0;
  localparam logic [2:0] MODE_FREE   = 3'd1;
  localparam logic [2:0] MODE_READY  = 3'd2;
  localparam logic [2:0] MODE_SCHED  = 3'd3;
  localparam logic [2:0] MODE_LINK   = 3'd4;
  localparam logic [2:0] MODE_ZOMBIE = 3'd5;
  localparam logic [2:0] MODE_FIND   = 3'd6;

  // Slot status codes.
  localparam logic [2:0] ST_UNUSED  = 3'd0;
  localparam logic [2:0] ST_UNINIT  = 3'd1;
  localparam logic [2:0] ST_READY   = 3'd2;
  localparam logic [2:0] ST_RUNNING = 3'd3;
  localparam logic [2:0] ST_BLOCKED = 3'd4;
  localparam logic [2:0] ST_ZOMBIE  = 3'd5;

  // Schedule actions on the current slot.
  localparam logic [1:0] ACT_YIELD = 2'd1;
  localparam logic [1:0] ACT_BLOCK = 2'd2;

  // Result codes.
  localparam logic [1:0] CODE_OK      = 2'd0;
  localparam logic [1:0] CODE_NONE    = 2'd1;
  localparam logic [1:0] CODE_REFUSED = 2'd2;

  typedef struct packed {
    logic [2:0]         mode;
    logic [5:0]         slot;
    logic signed [31:0] exit_value;
    logic [1:0]         curr_action;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         code;
    logic [5:0]         result_slot;
    logic [14:0]        pid_out;
    logic signed [31:0] exit_out;
    logic               wake_valid;
    logic [5:0]         wake_slot;
  } out_word_t;

  // Decoded view of one table entry.
  typedef struct packed {
    logic unused;
    logic ready;
    logic running;
    logic zombie;
    logic child;
  } entry_flags_t;

endpackage

// ----- rtl/ptrr_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptrr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/ptrr_entry.sv -----
// ----------------------------------------------------------------------------
// Process table entry decoder
// Resolves one read entry against its reset value and compares it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptrr_entry #(
  parameter int SLOTS = 64,
  localparam int IW = $clog2(SLOTS),
  localparam int MW = IW + 4
) (
  input  logic [MW-1:0]           rd_data_i,
  input  logic                    written_i,
  input  logic [IW-1:0]           addr_i,
  input  logic [IW-1:0]           target_i,
  output logic [2:0]              status_o,
  output logic                    pval_o,
  output logic [IW-1:0]           pidx_o,
  output ptrr_pkg::entry_flags_t  flags_o
);

  import ptrr_pkg::*;

  // An entry never written still holds its reset value: slot 0 running,
  // every other slot unused, and no parent.
  always_comb begin
    if (written_i) begin
      status_o = rd_data_i[MW-1 -: 3];
      pval_o   = rd_data_i[IW];
      pidx_o   = rd_data_i[IW-1:0];
    end else begin
      status_o = (addr_i == '0) ? ST_RUNNING : ST_UNUSED;
      pval_o   = 1'b0;
      pidx_o   = '0;
    end
  end

  assign flags_o.unused  = (status_o == ST_UNUSED);
  assign flags_o.ready   = (status_o == ST_READY);
  assign flags_o.running = (status_o == ST_RUNNING);
  assign flags_o.zombie  = (status_o == ST_ZOMBIE);
  assign flags_o.child   = pval_o && (pidx_o == target_i);

endmodule

// ----- rtl/process_table_round_robin.sv -----
// ----------------------------------------------------------------------------
// Process table with round-robin scheduler
// An unknown mode or an out-of-range slot goes straight to the result once the word
// is taken; free, ready and link first read and check the target entry; allocate, find
// zombie, zombie and schedule walk the table one entry per cycle. One word at a time:
// the next word is taken once the sequencer is back in idle after the result is
// loaded. A stalled result only holds back the following result.
// Reset clears control at once; per-entry written bits supply reset values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "process_table_round_robin_defines.svh"

module process_table_round_robin #(
  parameter int SLOTS   = 64,
  parameter int PID_MAX = 32767
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  ptrr_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ptrr_pkg::out_word_t out_word_o
);

  import ptrr_pkg::*;

  localparam int IW = $clog2(SLOTS);
  localparam int CW = IW + 1;
  localparam int MW = IW + 4;
  localparam int PW = $clog2(PID_MAX + 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_READ  = 5'b00010,
    S_CHECK = 5'b00100,
    S_SCAN  = 5'b01000,
    S_DONE  = 5'b10000
  } state_e;

  state_e          state_q, state_d;
  logic [2:0]      mode_q, mode_d;
  logic [IW-1:0]   slot_q, slot_d;
  logic [31:0]     exit_q, exit_d;
  logic [1:0]      act_q, act_d;
  logic [IW-1:0]   cur_q, cur_d;
  logic [PW-1:0]   pid_q, pid_d;
  logic [SLOTS-1:0] written_q, written_d;
  logic [IW-1:0]   addr_q, addr_d;
  logic [CW-1:0]   step_q, step_d;
  logic [CW-1:0]   span_q, span_d;
  logic            dv_q;
  logic [IW-1:0]   rd_addr_q;
  logic            vld_q;
  out_word_t       res_q, res_d;
  out_word_t       out_q, out_d;
  logic            out_valid_q, out_valid_d;

  logic            rd_en;
  logic            meta_we, pid_we, exit_we;
  logic [MW-1:0]   meta_wdata;
  logic [MW-1:0]   meta_rdata;
  logic [PW-1:0]   pid_rdata;
  logic [31:0]     exit_rdata;

  logic [2:0]      ent_status;
  logic            ent_pval;
  logic [IW-1:0]   ent_pidx;
  entry_flags_t    ent_flags;

  logic [IW-1:0]   in_slot;
  logic            in_range;

  function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] a);
    return (a == IW'(SLOTS - 1)) ? '0 : a + 1'b1;
  endfunction

  assign in_slot  = IW'(in_word_i.slot);
  assign in_range = ({26'd0, in_word_i.slot} < 32'(SLOTS));

  // Table storage: status and parent link share one word per slot.
  ptrr_ram #(.WIDTH(MW), .DEPTH(SLOTS)) u_meta_ram (
    .clk_i   (clk_i),
    .we_i    (meta_we),
    .waddr_i (rd_addr_q),
    .wdata_i (meta_wdata),
    .re_i    (rd_en),
    .raddr_i (addr_q),
    .rdata_o (meta_rdata)
  );

  ptrr_ram #(.WIDTH(PW), .DEPTH(SLOTS)) u_pid_ram (
    .clk_i   (clk_i),
    .we_i    (pid_we),
    .waddr_i (rd_addr_q),
    .wdata_i (pid_q),
    .re_i    (rd_en),
    .raddr_i (addr_q),
    .rdata_o (pid_rdata)
  );

  ptrr_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_exit_ram (
    .clk_i   (clk_i),
    .we_i    (exit_we),
    .waddr_i (rd_addr_q),
    .wdata_i (exit_q),
    .re_i    (rd_en),
    .raddr_i (addr_q),
    .rdata_o (exit_rdata)
  );

  ptrr_entry #(.SLOTS(SLOTS)) u_entry (
    .rd_data_i (meta_rdata),
    .written_i (vld_q),
    .addr_i    (rd_addr_q),
    .target_i  (slot_q),
    .status_o  (ent_status),
    .pval_o    (ent_pval),
    .pidx_o    (ent_pidx),
    .flags_o   (ent_flags)
  );

  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    slot_d      = slot_q;
    exit_d      = exit_q;
    act_d       = act_q;
    cur_d       = cur_q;
    pid_d       = pid_q;
    written_d   = written_q;
    addr_d      = addr_q;
    step_d      = step_q;
    span_d      = span_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    rd_en       = 1'b0;
    meta_we     = 1'b0;
    pid_we      = 1'b0;
    exit_we     = 1'b0;
    meta_wdata  = '0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          mode_d     = in_word_i.mode;
          slot_d     = in_slot;
          exit_d     = in_word_i.exit_value;
          act_d      = in_word_i.curr_action;
          res_d      = '0;
          res_d.code = CODE_NONE;
          step_d     = '0;
          span_d     = CW'(SLOTS);
          case (in_word_i.mode)
            MODE_ALLOC: begin
              addr_d  = IW'(1);
              span_d  = CW'(SLOTS - 1);
              state_d = S_SCAN;
            end
            MODE_FREE, MODE_READY, MODE_LINK, MODE_ZOMBIE: begin
              addr_d  = in_slot;
              state_d = in_range ? S_READ : S_DONE;
            end
            MODE_SCHED: begin
              if (in_word_i.curr_action == ACT_YIELD ||
                  in_word_i.curr_action == ACT_BLOCK) begin
                addr_d  = cur_q;
                state_d = S_READ;
              end else begin
                addr_d  = wrap_inc(cur_q);
                state_d = S_SCAN;
              end
            end
            MODE_FIND: begin
              addr_d  = '0;
              state_d = in_range ? S_SCAN : S_DONE;
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end

      S_READ: begin
        rd_en   = 1'b1;
        state_d = S_CHECK;
      end

      // Read-modify-write of the single target entry.
      S_CHECK: begin
        meta_wdata = {ent_status, ent_pval, ent_pidx};
        state_d    = S_DONE;
        case (mode_q)
          MODE_FREE: begin
            if (ent_flags.running) begin
              res_d.code = CODE_REFUSED;
            end else begin
              meta_we    = 1'b1;
              meta_wdata = {ST_UNUSED, ent_pval, ent_pidx};
              res_d.code = CODE_OK;
            end
          end
          MODE_READY: begin
            meta_we    = 1'b1;
            meta_wdata = {ST_READY, ent_pval, ent_pidx};
            res_d.code = CODE_OK;
          end
          MODE_LINK: begin
            meta_we    = 1'b1;
            meta_wdata = {ent_status, 1'b1, cur_q};
            res_d.code = CODE_OK;
          end
          MODE_ZOMBIE: begin
            meta_we    = 1'b1;
            exit_we    = 1'b1;
            meta_wdata = {ST_ZOMBIE, ent_pval, ent_pidx};
            res_d.code = CODE_OK;
            // A self link is dropped by the orphan pass, so it wakes nobody.
            res_d.wake_valid = ent_pval && (ent_pidx != slot_q);
            res_d.wake_slot  = res_d.wake_valid ? 6'(ent_pidx) : 6'd0;
            addr_d     = '0;
            step_d     = '0;
            state_d    = S_SCAN;
          end
          MODE_SCHED: begin
            meta_we    = 1'b1;
            meta_wdata = {(act_q == ACT_YIELD) ? ST_READY : ST_BLOCKED,
                          ent_pval, ent_pidx};
            addr_d     = wrap_inc(cur_q);
            step_d     = '0;
            state_d    = S_SCAN;
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end

      // One read is issued per cycle; the entry read in the previous cycle
      // is examined and, where needed, written back.
      S_SCAN: begin
        if (step_q < span_q) begin
          rd_en  = 1'b1;
          addr_d = wrap_inc(addr_q);
          step_d = step_q + 1'b1;
        end
        if (dv_q) begin
          case (mode_q)
            MODE_ALLOC: begin
              if (ent_flags.unused) begin
                meta_we    = 1'b1;
                pid_we     = 1'b1;
                meta_wdata = {ST_UNINIT, 1'b0, {IW{1'b0}}};
                pid_d      = (pid_q == PW'(PID_MAX)) ? PW'(1) : pid_q + 1'b1;
                res_d.code        = CODE_OK;
                res_d.result_slot = 6'(rd_addr_q);
                res_d.pid_out     = 15'(pid_q);
                state_d    = S_DONE;
              end
            end
            MODE_SCHED: begin
              if (ent_flags.ready) begin
                meta_we    = 1'b1;
                meta_wdata = {ST_RUNNING, ent_pval, ent_pidx};
                cur_d      = rd_addr_q;
                res_d.code        = CODE_OK;
                res_d.result_slot = 6'(rd_addr_q);
                state_d    = S_DONE;
              end
            end
            MODE_ZOMBIE: begin
              if (ent_flags.child) begin
                meta_we    = 1'b1;
                meta_wdata = {ent_status, 1'b0, {IW{1'b0}}};
              end
            end
            MODE_FIND: begin
              if (ent_flags.child && ent_flags.zombie) begin
                res_d.code        = CODE_OK;
                res_d.result_slot = 6'(rd_addr_q);
                res_d.pid_out     = 15'(pid_rdata);
                res_d.exit_out    = exit_rdata;
                state_d    = S_DONE;
              end
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
          if (state_d == S_SCAN && step_q == span_q) begin
            if (mode_q == MODE_SCHED) begin
              res_d.result_slot = 6'(cur_q);
            end
            state_d = S_DONE;
          end
        end
      end

      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (meta_we) begin
      written_d[rd_addr_q] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cur_q       <= '0;
      pid_q       <= PW'(1);
      written_q   <= '0;
      step_q      <= '0;
      span_q      <= '0;
      dv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cur_q       <= cur_d;
      pid_q       <= pid_d;
      written_q   <= written_d;
      step_q      <= step_d;
      span_q      <= span_d;
      dv_q        <= rd_en;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q <= mode_d;
    slot_q <= slot_d;
    exit_q <= exit_d;
    act_q  <= act_d;
    addr_q <= addr_d;
    res_q  <= res_d;
    out_q  <= out_d;
    if (rd_en) begin
      rd_addr_q <= addr_q;
      vld_q     <= written_q[addr_q];
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  `PTRR_ASSERT_NEXT(a_accept_busy, in_valid_i && !in_stall_o, state_q != S_IDLE, "accepted word left the sequencer idle")
  `PTRR_ASSERT_NOW(a_write_state, meta_we, state_q == S_CHECK || state_q == S_SCAN, "table written outside check or scan")
  `PTRR_ASSERT_NOW(a_scan_bound, state_q == S_SCAN, step_q <= span_q, "scan ran past its span")
  `PTRR_ASSERT_NEXT(a_result_load, state_q == S_DONE && (!out_valid_q || !out_stall_i), out_valid_q && state_q == S_IDLE, "result not loaded")
  `PTRR_ASSERT_NOW(a_pid_nonzero, 1'b1, pid_q != '0, "pid counter reached zero")

endmodule
